/* src/dfkh_pkg.sv */
// package for the dual fnv-1a 64-bit key hasher
// holds the hash constants, counter width and shared types; no dependencies
`default_nettype none

package dfkh_pkg;

    localparam int unsigned COUNT_BITS  = 32;
    localparam int unsigned HASH_BITS   = 64;
    localparam int unsigned LENGTH_BITS = 32;
    localparam int unsigned BYTE_BITS   = 8;

    localparam int unsigned OUT_BITS = 2 * HASH_BITS + LENGTH_BITS;

    localparam logic [HASH_BITS-1:0] BASIS_STANDARD = 64'hcbf2_9ce4_8422_2325;
    localparam logic [HASH_BITS-1:0] BASIS_REVERSED = 64'h8422_2325_cbf2_9ce4;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    typedef logic [HASH_BITS-1:0]   hash_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [LENGTH_BITS-1:0] length_t;

    typedef struct packed {
        hash_t   hash_standard;
        hash_t   hash_reversed;
        length_t message_length;
    } result_t;

    // clamp a byte count to the width of the length field
    function automatic length_t clamp_length(input count_t count);
        logic [63:0] wide;
        wide = 64'(count);
        clamp_length = (wide > 64'(LENGTH_MAX)) ? LENGTH_MAX : wide[LENGTH_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/dfkh_absorb.sv */
// one fnv-1a absorb step: xor in a byte, multiply by the 64-bit prime
// prime 2^40 + 2^8 + 0xb3 is built as a shift-add; uses dfkh_pkg
`default_nettype none

module dfkh_absorb
    import dfkh_pkg::*;
(
    input  wire hash_t                h,
    input  wire logic [BYTE_BITS-1:0] b,
    output hash_t                     h_next
);

    hash_t x;

    assign x = h ^ HASH_BITS'(b);

    // 0xb3 = 2^7 + 2^5 + 2^4 + 2^1 + 1
    assign h_next = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                  + (x << 1) + x;

endmodule

`default_nettype wire

/* src/dual_fnv1a64_key_hasher.sv */
// dual fnv-1a 64-bit key hasher: one message byte per item, two hashes side by side
// result path: the final byte is held in the input register, then the result goes to the result register
// throughput: one byte per cycle when not stalled; the state update is a single shift-add per hash
// stalls only while a finished result waits on the output and a final byte is queued
// reset: async active low, hashes back to their offset bases, count to zero, no result held
// depends on dfkh_pkg and dfkh_absorb
`default_nettype none

module dual_fnv1a64_key_hasher
    import dfkh_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  wire logic                s_axis_tlast,   // final_byte

    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OUT_BITS-1:0]      m_axis_tdata    // [63:0] hash_standard,
                                                     // [127:64] hash_reversed,
                                                     // [159:128] message_length
);

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 in_last_reg;

    // running state
    hash_t  run_std_reg, run_std_next;
    hash_t  run_rev_reg, run_rev_next;
    count_t count_reg,   count_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    hash_t  abs_std, abs_rev;
    count_t count_inc;
    logic   advance;
    logic   out_free;

    dfkh_absorb u_absorb_std
    (
        .h      (run_std_reg),
        .b      (in_byte_reg),
        .h_next (abs_std)
    );

    dfkh_absorb u_absorb_rev
    (
        .h      (run_rev_reg),
        .b      (in_byte_reg),
        .h_next (abs_rev)
    );

    // saturating byte counter
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    // a held byte moves on unless it is final and the result slot is still full
    assign advance = in_valid_reg && (!in_last_reg || out_free);

    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        run_std_next   = run_std_reg;
        run_rev_next   = run_rev_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            if (in_last_reg)
            begin
                // message done: hand off and restart from the bases
                run_std_next   = BASIS_STANDARD;
                run_rev_next   = BASIS_REVERSED;
                count_next     = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                run_std_next = abs_std;
                run_rev_next = abs_rev;
                count_next   = count_inc;
            end
        end

        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_std_reg   <= BASIS_STANDARD;
            run_rev_reg   <= BASIS_REVERSED;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            run_std_reg   <= run_std_next;
            run_rev_reg   <= run_rev_next;
            count_reg     <= count_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[BYTE_BITS-1:0];
            in_last_reg <= s_axis_tlast;
        end

        if (advance && in_last_reg)
        begin
            out_reg.hash_standard  <= abs_std;
            out_reg.hash_reversed  <= abs_rev;
            out_reg.message_length <= clamp_length(count_inc);
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    // struct packs first member high; tdata puts hash_standard lowest
    assign m_axis_tdata = {out_reg.message_length, out_reg.hash_reversed,
                           out_reg.hash_standard};

endmodule

`default_nettype wire
